/* hdl/equirect_reprojection_assert.svh */
// ----------------------------------------------------------------------------
// equirect_reprojection_assert.svh
// Assertion macros used by the equirect_reprojection module.
// ----------------------------------------------------------------------------
`ifndef EQUIRECT_REPROJECTION_ASSERT_SVH
`define EQUIRECT_REPROJECTION_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define EQR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EQR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/eqr_pkg.sv */
// ----------------------------------------------------------------------------
// eqr_pkg
// Shared types, constants and the arctangent table of the reprojection block.
// ----------------------------------------------------------------------------
package eqr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SCREEN_BITS   = 12;

  localparam int VEC_W = 34;
  localparam int ANG_W = 17;

  localparam int ANG_PI      = 25736;
  localparam int ANG_HALF_PI = 12868;
  localparam int INV_GAIN    = 19899;

  localparam int DIV_SHIFT = 46;
  localparam longint COL_DIV = 51472;
  localparam longint ROW_DIV = 25736;
  localparam logic [31:0] COL_RECIP = 32'((64'd1 << DIV_SHIFT) / 64'd51472);
  localparam logic [31:0] ROW_RECIP = 32'((64'd1 << DIV_SHIFT) / 64'd25736);

  localparam logic [2:0] REG_COS_PITCH    = 3'd0;
  localparam logic [2:0] REG_SIN_PITCH    = 3'd1;
  localparam logic [2:0] REG_FOCAL_LENGTH = 3'd2;
  localparam logic [2:0] REG_PRINC_COL    = 3'd3;
  localparam logic [2:0] REG_PRINC_ROW    = 3'd4;
  localparam logic [2:0] REG_PANO_WIDTH   = 3'd5;
  localparam logic [2:0] REG_PANO_HEIGHT  = 3'd6;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  typedef struct packed {
    logic valid;
    vec_t x;
    vec_t y;
    vec_t side;
  } cordic_in_t;

  typedef struct packed {
    logic valid;
    vec_t mag;
    ang_t ang;
    vec_t side;
  } cordic_out_t;

  // round(atan(2^-i) * 8192)
  function automatic ang_t atan_lut(input logic [4:0] idx);
    ang_t r;
    unique case (idx)
      5'd0:    r = 17'sd6434;
      5'd1:    r = 17'sd3798;
      5'd2:    r = 17'sd2007;
      5'd3:    r = 17'sd1019;
      5'd4:    r = 17'sd511;
      5'd5:    r = 17'sd256;
      5'd6:    r = 17'sd128;
      5'd7:    r = 17'sd64;
      5'd8:    r = 17'sd32;
      5'd9:    r = 17'sd16;
      5'd10:   r = 17'sd8;
      5'd11:   r = 17'sd4;
      5'd12:   r = 17'sd2;
      5'd13:   r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/eqr_cordic.sv */
// ----------------------------------------------------------------------------
// eqr_cordic
// Pipelined vectoring CORDIC: atan2(y, x) and scaled magnitude, one stage
// per iteration plus a quadrant pre-rotation stage. Side data rides along.
// ----------------------------------------------------------------------------
module eqr_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  eqr_pkg::cordic_in_t  din,
  output eqr_pkg::cordic_out_t dout
);

  localparam int N = eqr_pkg::CORDIC_STAGES;

  logic                v   [0:N];
  logic                zro [0:N];
  eqr_pkg::vec_t       xs  [0:N];
  eqr_pkg::vec_t       ys  [0:N];
  eqr_pkg::ang_t       zs  [0:N];
  eqr_pkg::vec_t       sd  [0:N];

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= din.valid;
    end
    if (en) begin
      zro[0] <= (din.x == '0) && (din.y == '0);
      sd[0]  <= din.side;
      if (din.x[eqr_pkg::VEC_W-1]) begin
        if (!din.y[eqr_pkg::VEC_W-1]) begin
          xs[0] <= din.y;
          ys[0] <= -din.x;
          zs[0] <= eqr_pkg::ANG_W'(eqr_pkg::ANG_HALF_PI);
        end else begin
          xs[0] <= -din.y;
          ys[0] <= din.x;
          zs[0] <= -eqr_pkg::ANG_W'(eqr_pkg::ANG_HALF_PI);
        end
      end else begin
        xs[0] <= din.x;
        ys[0] <= din.y;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        zro[i+1] <= zro[i];
        sd[i+1]  <= sd[i];
        if (!ys[i][eqr_pkg::VEC_W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + eqr_pkg::atan_lut(5'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - eqr_pkg::atan_lut(5'(i));
        end
      end
    end
  end

  assign dout.valid = v[N];
  assign dout.mag   = xs[N];
  assign dout.ang   = zro[N] ? '0 : zs[N];
  assign dout.side  = sd[N];

endmodule

/* hdl/equirect_reprojection.sv */
// ----------------------------------------------------------------------------
// equirect_reprojection
// Screen pixel to equirectangular panorama coordinate, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one screen pixel per clock unless stalled and returns its panorama
// column and row via offset, rotation, both CORDIC, scaling, reciprocal,
// correction and output registers; all advance together and hold while
// m_tready is low with a result waiting. Configuration must be written
// through cfg_we/cfg_addr/cfg_wdata only while idle; the block has no guard.
module equirect_reprojection (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // screen_col[11:0], screen_row[23:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pano_col[12:0], pano_row[25:13], zero pad
  output logic        m_tuser,   // coord_valid
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int SB = eqr_pkg::SCREEN_BITS;
  localparam int VW = eqr_pkg::VEC_W;
  localparam int AW = eqr_pkg::ANG_W;

  logic signed [15:0] cos_pitch, sin_pitch;
  logic [12:0] focal_length;
  logic [11:0] princ_col, princ_row;
  logic [13:0] pano_width, pano_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_pitch    <= 16'sd14378;
      sin_pitch    <= 16'sd7855;
      focal_length <= 13'd672;
      princ_col    <= 12'd960;
      princ_row    <= 12'd540;
      pano_width   <= 14'd3840;
      pano_height  <= 14'd1920;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        eqr_pkg::REG_COS_PITCH:    cos_pitch    <= cfg_wdata;
        eqr_pkg::REG_SIN_PITCH:    sin_pitch    <= cfg_wdata;
        eqr_pkg::REG_FOCAL_LENGTH: focal_length <= cfg_wdata[12:0];
        eqr_pkg::REG_PRINC_COL:    princ_col    <= cfg_wdata[11:0];
        eqr_pkg::REG_PRINC_ROW:    princ_row    <= cfg_wdata[11:0];
        eqr_pkg::REG_PANO_WIDTH:   pano_width   <= cfg_wdata[13:0];
        eqr_pkg::REG_PANO_HEIGHT:  pano_height  <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [SB-1:0] scol, srow;
  assign scol = SB'(s_tdata[11:0]);
  assign srow = SB'(s_tdata[23:12]);

  // p1: offsets from principal point
  logic v1;
  logic signed [14:0] dx1, dy1;
  // p2: rotation products
  logic v2;
  logic signed [14:0] dx2;
  logic signed [31:0] p_cdy, p_sf, p_sdy, p_cf;
  // p3: rotated ray
  eqr_pkg::cordic_in_t  ca_in, cb_in;
  eqr_pkg::cordic_out_t ca_out, cb_out;
  // p4: gain removal
  logic signed [VW+15:0] gain_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ca_in.valid <= 1'b0;
      cb_in.valid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      ca_in.valid <= v2;
      cb_in.valid <= ca_out.valid;
    end
    if (en) begin
      dx1   <= $signed(15'(scol)) - $signed({3'b000, princ_col});
      dy1   <= $signed(15'(srow)) - $signed({3'b000, princ_row});
      dx2   <= dx1;
      p_cdy <= 32'(cos_pitch * dy1);
      p_sdy <= 32'(sin_pitch * dy1);
      p_sf  <= 32'(sin_pitch * $signed({1'b0, focal_length}));
      p_cf  <= 32'(cos_pitch * $signed({1'b0, focal_length}));
      ca_in.y    <= VW'(dx2) <<< 14;
      ca_in.x    <= VW'(p_sdy) + VW'(p_cf);
      ca_in.side <= VW'(p_cdy) - VW'(p_sf);
      cb_in.x    <= VW'(gain_prod >>> 15);
      cb_in.y    <= ca_out.side;
      cb_in.side <= VW'(ca_out.ang);
    end
  end

  assign gain_prod = ca_out.mag * $signed({1'b0, 15'(eqr_pkg::INV_GAIN)});

  eqr_cordic u_cordic_phi (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (ca_in),
    .dout (ca_out)
  );

  eqr_cordic u_cordic_theta (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (cb_in),
    .dout (cb_out)
  );

  // p5: scale numerators
  logic v5, v6, v7;
  logic signed [32:0] cnum5, rnum5;
  eqr_pkg::ang_t phi, theta;
  assign phi   = cb_out.side[AW-1:0];
  assign theta = cb_out.ang;

  // p6: reciprocal estimate
  logic neg6;
  logic [30:0] cnum6, rnum6;
  logic [16:0] cq6, rq6;
  logic [62:0] cprod, rprod;
  assign cprod = 63'(cnum5[30:0] * eqr_pkg::COL_RECIP);
  assign rprod = 63'(rnum5[30:0] * eqr_pkg::ROW_RECIP);

  // p7: one-step correction
  logic neg7;
  logic [16:0] cq7, rq7;
  logic [32:0] crem, rrem;
  assign crem = 33'(cnum6) - 33'(cq6 * 16'(eqr_pkg::COL_DIV));
  assign rrem = 33'(rnum6) - 33'(rq6 * 15'(eqr_pkg::ROW_DIV));

  // p8: caps and output register
  logic [13:0] wcap, hcap;
  assign wcap = (pano_width == '0) ? '0 :
                (pano_width > 14'd8192 ? 14'd8191 : pano_width - 1'b1);
  assign hcap = (pano_height == '0) ? '0 :
                (pano_height > 14'd8192 ? 14'd8191 : pano_height - 1'b1);

  logic [12:0] pano_col, pano_row;
  logic coord_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v5 <= cb_out.valid;
      v6 <= v5;
      v7 <= v6;
      m_tvalid <= v7;
    end
    if (en) begin
      cnum5 <= ($signed({phi[AW-1], phi}) + 18'sd25736) * $signed({1'b0, pano_width});
      rnum5 <= ($signed({theta[AW-1], theta}) + 18'sd12868) *
               $signed({1'b0, pano_height});
      neg6  <= cnum5[32] || rnum5[32];
      cnum6 <= cnum5[30:0];
      rnum6 <= rnum5[30:0];
      cq6   <= cprod[eqr_pkg::DIV_SHIFT +: 17];
      rq6   <= rprod[eqr_pkg::DIV_SHIFT +: 17];
      neg7  <= neg6;
      cq7   <= cq6 + 17'(crem >= 33'(eqr_pkg::COL_DIV));
      rq7   <= rq6 + 17'(rrem >= 33'(eqr_pkg::ROW_DIV));
      coord_valid <= !neg7;
      pano_col <= neg7 ? '0 : (cq7 > 17'(wcap) ? wcap[12:0] : cq7[12:0]);
      pano_row <= neg7 ? '0 : (rq7 > 17'(hcap) ? hcap[12:0] : rq7[12:0]);
    end
  end

  assign m_tdata = {6'b0, pano_row, pano_col};
  assign m_tuser = coord_valid;

  `include "equirect_reprojection_assert.svh"

  `EQR_ASSERT_NOW(a_invalid_zero, m_tvalid && !coord_valid, m_tdata == '0, "coord not cleared")
  `EQR_ASSERT_NOW(a_col_bound, m_tvalid && pano_width != '0, 14'(pano_col) < pano_width, "col range")
  `EQR_ASSERT_NOW(a_row_bound, m_tvalid && pano_height != '0, 14'(pano_row) < pano_height, "row range")
  `EQR_ASSERT_NOW(a_mag_pos, ca_out.valid, !ca_out.mag[VW-1], "negative CORDIC magnitude")

endmodule
